/* design/gtc_pkg.sv */
// Shared types, constants and register codes of the touch gesture classifier.
`timescale 1ns / 1ps
package gtc_pkg;

   // Raw panel and screen geometry
   localparam int unsigned RAW_WIDTH     = 1000;
   localparam int unsigned RAW_HEIGHT    = 600;
   localparam int unsigned SCREEN_WIDTH  = 800;
   localparam int unsigned SCREEN_HEIGHT = 480;

   // Field widths
   localparam int unsigned TYPE_W    = 5;
   localparam int unsigned CODE_W    = 10;
   localparam int unsigned COORD_W   = 10;
   localparam int unsigned CFG_W     = 10;
   localparam int unsigned GEST_W    = 3;
   localparam int unsigned START_W   = COORD_W + 1;
   localparam int unsigned DIFF_W    = COORD_W + 2;
   localparam int unsigned DISP_W    = COORD_W + 1;
   localparam int unsigned CSR_IDX_W = 2;

   // Shared multiplier
   localparam int unsigned MUL_W  = 32;
   localparam int unsigned PROD_W = 2 * MUL_W;
   localparam int unsigned PIN_W  = COORD_W + COORD_W;   // raw * screen
   localparam int unsigned SCALE_K = 30;                  // reciprocal fraction bits
   localparam longint unsigned RECIP_X =
      ((64'd1 << SCALE_K) + RAW_WIDTH - 1) / RAW_WIDTH;
   localparam longint unsigned RECIP_Y =
      ((64'd1 << SCALE_K) + RAW_HEIGHT - 1) / RAW_HEIGHT;

   // Scaled coordinate range
   localparam int unsigned COORD_MAX = (1 << COORD_W) - 1;
   localparam int unsigned PX_MAX    = COORD_MAX * SCREEN_WIDTH / RAW_WIDTH;
   localparam int unsigned PY_MAX    = COORD_MAX * SCREEN_HEIGHT / RAW_HEIGHT;
   localparam int unsigned PXY_MAX   = (PX_MAX > PY_MAX) ? PX_MAX : PY_MAX;
   localparam int unsigned SCL_MAX   = (PXY_MAX > COORD_MAX) ? PXY_MAX : COORD_MAX;
   localparam int unsigned SCL_W     = $clog2(SCL_MAX + 1);
   localparam int unsigned SPX_W     = SCL_W + 1;         // signed scaled point
   localparam int unsigned OFS_W     = SCL_W + 2;         // signed offset from center
   localparam int unsigned MAG_W     = SCL_W + 1;         // offset magnitude
   localparam int unsigned SQ_W      = 2 * MAG_W;
   localparam int unsigned SUM_W     = SQ_W + 1;

   // Event codes
   localparam logic [TYPE_W-1:0]  EV_TYPE_KEY   = 5'd1;
   localparam logic [TYPE_W-1:0]  EV_TYPE_ABS   = 5'd3;
   localparam logic [CODE_W-1:0]  CODE_AXIS_X   = 10'd0;
   localparam logic [CODE_W-1:0]  CODE_AXIS_Y   = 10'd1;
   localparam logic [CODE_W-1:0]  CODE_TOUCH    = 10'd330;
   localparam logic [COORD_W-1:0] VALUE_RELEASE = 10'd0;

   // Register reset values
   localparam logic [CFG_W-1:0] TAP_THRESHOLD_RST   = 10'd10;
   localparam logic [CFG_W-1:0] BUTTON_CENTER_X_RST = 10'd400;
   localparam logic [CFG_W-1:0] BUTTON_CENTER_Y_RST = 10'd460;
   localparam logic [CFG_W-1:0] BUTTON_RADIUS_RST   = 10'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_THRESHOLD   = 2'd0,
      CSR_BUTTON_CENTER_X = 2'd1,
      CSR_BUTTON_CENTER_Y = 2'd2,
      CSR_BUTTON_RADIUS   = 2'd3
   } csr_index_type;

   typedef enum logic [GEST_W-1:0] {
      GEST_UP     = 3'd0,
      GEST_DOWN   = 3'd1,
      GEST_LEFT   = 3'd2,
      GEST_RIGHT  = 3'd3,
      GEST_CENTER = 3'd4,
      GEST_TAP    = 3'd5
   } gesture_type;

   typedef struct packed {
      logic [TYPE_W-1:0]  event_type;
      logic [CODE_W-1:0]  event_code;
      logic [COORD_W-1:0] event_value;
   } req_type;

   typedef struct packed {
      gesture_type        gesture;
      logic [COORD_W-1:0] tap_x;
      logic [COORD_W-1:0] tap_y;
   } rsp_type;

   typedef struct packed {
      logic [CFG_W-1:0] tap_threshold;
      logic [CFG_W-1:0] button_center_x;
      logic [CFG_W-1:0] button_center_y;
      logic [CFG_W-1:0] button_radius;
   } cfg_type;

   typedef struct packed {
      logic signed [START_W-1:0] start_x;
      logic signed [START_W-1:0] start_y;
      logic [COORD_W-1:0]        latest_x;
      logic [COORD_W-1:0]        latest_y;
   } touch_type;

   typedef struct packed {
      logic               x_we;
      logic               y_we;
      logic               clear;
      logic [COORD_W-1:0] value;
   } touch_upd_type;

   typedef struct packed {
      logic [MUL_W-1:0] a;
      logic [MUL_W-1:0] b;
   } mul_op_type;

endpackage

/* design/gtc_mul_unit.sv */
// Shared registered multiplier of the touch gesture classifier.
`timescale 1ns / 1ps
module gtc_mul_unit (
   input  logic                       clock,
   input  gtc_pkg::mul_op_type        op,
   output logic [gtc_pkg::PROD_W-1:0] prod
);
   import gtc_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op.a) * PROD_W'(op.b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

/* design/gtc_touch_state.sv */
// First and latest touch coordinates of the touch in progress.
`timescale 1ns / 1ps
module gtc_touch_state (
   input  logic                   clock,
   input  logic                   reset,
   input  gtc_pkg::touch_upd_type upd,
   output gtc_pkg::touch_type     touch
);
   import gtc_pkg::*;

   touch_type touch_ff;
   touch_type touch_in;

   always_comb begin
      touch_in = touch_ff;
      if (upd.clear) begin
         touch_in.start_x  = '1;   // -1: not seen
         touch_in.start_y  = '1;
         touch_in.latest_x = '0;
         touch_in.latest_y = '0;
      end else begin
         if (upd.x_we) begin
            if (touch_ff.start_x < 0) touch_in.start_x = $signed({1'b0, upd.value});
            touch_in.latest_x = upd.value;
         end
         if (upd.y_we) begin
            if (touch_ff.start_y < 0) touch_in.start_y = $signed({1'b0, upd.value});
            touch_in.latest_y = upd.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_ff.start_x  <= '1;
         touch_ff.start_y  <= '1;
         touch_ff.latest_x <= '0;
         touch_ff.latest_y <= '0;
      end else begin
         touch_ff <= touch_in;
      end
   end

   assign touch = touch_ff;

endmodule

/* design/gtc_sequencer.sv */
// Event decode, gesture sequencer and result register.
`timescale 1ns / 1ps
module gtc_sequencer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  gtc_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output gtc_pkg::rsp_type           rsp_data,
   input  gtc_pkg::cfg_type           cfg,
   input  gtc_pkg::touch_type         touch,
   output gtc_pkg::touch_upd_type     upd,
   output gtc_pkg::mul_op_type        mul_op,
   input  logic [gtc_pkg::PROD_W-1:0] prod
);
   import gtc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_XA, S_XB, S_YA, S_YB, S_SQX, S_SQY, S_SQR, S_CMP, S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   rsp_type                 res_ff, res_in;
   logic signed [SPX_W-1:0] px_ff, px_in;
   logic signed [SPX_W-1:0] py_ff, py_in;
   logic [SQ_W-1:0]         sqx_ff, sqx_in;
   logic [SUM_W-1:0]        sum_ff, sum_in;

   logic                     accept, is_abs, is_release, is_tap, out_free;
   logic signed [DIFF_W-1:0] dx_s, dy_s, dx_abs, dy_abs;
   logic [DISP_W-1:0]        dx_mag, dy_mag;
   logic [CFG_W:0]           thr_ext;
   gesture_type              swipe;
   logic signed [START_W-1:0] sx_neg, sy_neg;
   logic [COORD_W-1:0]       sx_mag, sy_mag;
   logic [SCL_W-1:0]         quot;
   logic signed [SPX_W-1:0]  quot_pos;
   logic signed [OFS_W-1:0]  ox, oy, ox_abs, oy_abs;
   logic [MAG_W-1:0]         ox_mag, oy_mag;

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign is_abs     = (req_data.event_type == EV_TYPE_ABS);
   assign is_release = (req_data.event_type == EV_TYPE_KEY) &&
                       (req_data.event_code == CODE_TOUCH) &&
                       (req_data.event_value == VALUE_RELEASE);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // Displacements
   always_comb begin
      dx_s    = $signed({2'b00, touch.latest_x}) - $signed({touch.start_x[START_W-1], touch.start_x});
      dy_s    = $signed({2'b00, touch.latest_y}) - $signed({touch.start_y[START_W-1], touch.start_y});
      dx_abs  = (dx_s < 0) ? -dx_s : dx_s;
      dy_abs  = (dy_s < 0) ? -dy_s : dy_s;
      dx_mag  = dx_abs[DISP_W-1:0];
      dy_mag  = dy_abs[DISP_W-1:0];
      thr_ext = {1'b0, cfg.tap_threshold};
      is_tap  = (dx_mag < DISP_W'(thr_ext)) && (dy_mag < DISP_W'(thr_ext));
      if (dx_mag > dy_mag) swipe = (dx_s > 0) ? GEST_RIGHT : GEST_LEFT;
      else                 swipe = (dy_s > 0) ? GEST_DOWN : GEST_UP;
   end

   // Scaling and circle operands
   always_comb begin
      sx_neg   = -touch.start_x;
      sy_neg   = -touch.start_y;
      sx_mag   = touch.start_x[START_W-1] ? sx_neg[COORD_W-1:0] : touch.start_x[COORD_W-1:0];
      sy_mag   = touch.start_y[START_W-1] ? sy_neg[COORD_W-1:0] : touch.start_y[COORD_W-1:0];
      quot     = prod[SCALE_K +: SCL_W];
      quot_pos = $signed({1'b0, quot});
      ox       = $signed({px_ff[SPX_W-1], px_ff}) - $signed(OFS_W'(cfg.button_center_x));
      oy       = $signed({py_ff[SPX_W-1], py_ff}) - $signed(OFS_W'(cfg.button_center_y));
      ox_abs   = (ox < 0) ? -ox : ox;
      oy_abs   = (oy < 0) ? -oy : oy;
      ox_mag   = ox_abs[MAG_W-1:0];
      oy_mag   = oy_abs[MAG_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      res_in       = res_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      sqx_in       = sqx_ff;
      sum_in       = sum_ff;
      upd          = '0;
      upd.value    = req_data.event_value;
      mul_op       = '0;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (is_abs) begin
                  upd.x_we = (req_data.event_code == CODE_AXIS_X);
                  upd.y_we = (req_data.event_code == CODE_AXIS_Y);
               end else if (is_release) begin
                  if (is_tap) begin
                     state_in = S_XA;
                  end else begin
                     res_in.gesture = swipe;
                     res_in.tap_x   = '0;
                     res_in.tap_y   = '0;
                     state_in       = S_DONE;
                  end
               end
            end
         end
         S_XA: begin
            mul_op.a = MUL_W'(sx_mag);
            mul_op.b = MUL_W'(SCREEN_WIDTH);
            state_in = S_XB;
         end
         S_XB: begin
            mul_op.a = MUL_W'(prod[PIN_W-1:0]);
            mul_op.b = MUL_W'(RECIP_X);
            state_in = S_YA;
         end
         S_YA: begin
            px_in    = touch.start_x[START_W-1] ? -quot_pos : quot_pos;
            mul_op.a = MUL_W'(sy_mag);
            mul_op.b = MUL_W'(SCREEN_HEIGHT);
            state_in = S_YB;
         end
         S_YB: begin
            mul_op.a = MUL_W'(prod[PIN_W-1:0]);
            mul_op.b = MUL_W'(RECIP_Y);
            state_in = S_SQX;
         end
         S_SQX: begin
            py_in    = touch.start_y[START_W-1] ? -quot_pos : quot_pos;
            mul_op.a = MUL_W'(ox_mag);
            mul_op.b = MUL_W'(ox_mag);
            state_in = S_SQY;
         end
         S_SQY: begin
            sqx_in   = prod[SQ_W-1:0];
            mul_op.a = MUL_W'(oy_mag);
            mul_op.b = MUL_W'(oy_mag);
            state_in = S_SQR;
         end
         S_SQR: begin
            sum_in   = SUM_W'(sqx_ff) + SUM_W'(prod[SQ_W-1:0]);
            mul_op.a = MUL_W'(cfg.button_radius);
            mul_op.b = MUL_W'(cfg.button_radius);
            state_in = S_CMP;
         end
         S_CMP: begin
            if (PROD_W'(sum_ff) < prod) begin
               res_in.gesture = GEST_CENTER;
               res_in.tap_x   = '0;
               res_in.tap_y   = '0;
            end else begin
               res_in.gesture = GEST_TAP;
               res_in.tap_x   = px_ff[COORD_W-1:0];
               res_in.tap_y   = py_ff[COORD_W-1:0];
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               upd.clear    = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      res_ff      <= res_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      sqx_ff      <= sqx_in;
      sum_ff      <= sum_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* design/touch_gesture_classifier.sv */
// Top level of the touch gesture classifier: register file and unit wiring.
`timescale 1ns / 1ps
// Classifies one touch per release event. Axis events (type 3, code 0 or 1)
// record the first and latest X/Y of the touch; other events that are not a
// touch release (type 1, code 330, value 0) are dropped. On a release the
// block stalls requests while it classifies: a swipe (up/down/left/right by
// the larger displacement) needs no multiplier, while a tap uses the single
// shared multiplier seven times in turn (two scaling products, two reciprocal
// multiplies, three squares for the center-button circle test).
// Tap coordinates are raw * screen / raw-size, truncated and not clamped;
// an axis never seen scales from -1. The result sits in an output register,
// so new requests are taken while an earlier result is still stalled; the
// next release result waits behind it. Touch state clears when the result
// is loaded. Registers (index 0..3: tap threshold, button center x, button
// center y, button radius) are written whenever csr_valid is high; write
// them only while no request is in flight.
module touch_gesture_classifier (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  gtc_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output gtc_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gtc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gtc_pkg::CFG_W-1:0]     csr_wdata
);
   import gtc_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   touch_type     touch;
   touch_upd_type upd;
   mul_op_type    mul_op;
   logic [PROD_W-1:0] prod;

   // Register file: always ready, one write per cycle.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TAP_THRESHOLD:   cfg_in.tap_threshold   = csr_wdata;
            CSR_BUTTON_CENTER_X: cfg_in.button_center_x = csr_wdata;
            CSR_BUTTON_CENTER_Y: cfg_in.button_center_y = csr_wdata;
            CSR_BUTTON_RADIUS:   cfg_in.button_radius   = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tap_threshold   <= TAP_THRESHOLD_RST;
         cfg_ff.button_center_x <= BUTTON_CENTER_X_RST;
         cfg_ff.button_center_y <= BUTTON_CENTER_Y_RST;
         cfg_ff.button_radius   <= BUTTON_RADIUS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;

   // Touch in progress
   gtc_touch_state u_touch (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .touch (touch)
   );

   // Shared multiplier, one registered product per cycle
   gtc_mul_unit u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   // Decode, classification sequence and result register
   gtc_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cfg       (cfg_ff),
      .touch     (touch),
      .upd       (upd),
      .mul_op    (mul_op),
      .prod      (prod)
   );

endmodule

/* test/touch_gesture_classifier_test.sv */
// Self-checking testbench for the touch gesture classifier.
`timescale 1ns / 1ps
module touch_gesture_classifier_test;
   import gtc_pkg::*;

   // Geometry as signed 64-bit values, so that scaling -1 truncates toward zero
   localparam longint SCR_W = SCREEN_WIDTH;
   localparam longint SCR_H = SCREEN_HEIGHT;
   localparam longint PANEL_W = RAW_WIDTH;
   localparam longint PANEL_H = RAW_HEIGHT;
   localparam int CYCLE_LIMIT = 300000;
   localparam int SETTLE_CYCLES = 20;     // longer than a tap keeps the block busy
   localparam int HOLD_CYCLES = 400;      // long receiver hold-off
   localparam int HOLD_AFTER = 40;        // results seen before the hold-off starts

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   touch_gesture_classifier dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Register copy, written only when the register write is taken
   logic [CFG_W-1:0] tap_thr = TAP_THRESHOLD_RST;
   logic [CFG_W-1:0] ctr_x = BUTTON_CENTER_X_RST;
   logic [CFG_W-1:0] ctr_y = BUTTON_CENTER_Y_RST;
   logic [CFG_W-1:0] radius = BUTTON_RADIUS_RST;

   // Touch tracking: first point (-1 = axis not seen yet) and latest point
   logic signed [START_W-1:0] first_x = '1;
   logic signed [START_W-1:0] first_y = '1;
   logic [COORD_W-1:0] last_x = '0;
   logic [COORD_W-1:0] last_y = '0;

   req_type pending_requests[$];     // filled by the sequence, drained by the driver
   rsp_type gestures_due[$];         // predicted gestures, oldest first
   int requests_queued = 0;          // axis and release requests only
   int results_seen = 0;
   int cycle_count = 0;
   bit idling = 1'b1;
   bit failed = 1'b0;

   // Timeout guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Update the touch state for one taken request; a release yields a gesture.
   task automatic track_request(input req_type rq);
      longint dx, dy, px, py, ox, oy, thr, rad;
      rsp_type g;
      if (rq.event_type == EV_TYPE_ABS) begin
         if (rq.event_code == CODE_AXIS_X) begin
            if (first_x < 0) first_x = $signed({1'b0, rq.event_value});
            last_x = rq.event_value;
         end else if (rq.event_code == CODE_AXIS_Y) begin
            if (first_y < 0) first_y = $signed({1'b0, rq.event_value});
            last_y = rq.event_value;
         end
      end else if (rq.event_type == EV_TYPE_KEY && rq.event_code == CODE_TOUCH &&
                   rq.event_value == VALUE_RELEASE) begin
         dx = longint'(last_x);
         dx = dx - longint'(first_x);
         if (dx < 0) dx = -dx;
         dy = longint'(last_y);
         dy = dy - longint'(first_y);
         if (dy < 0) dy = -dy;
         thr = longint'(tap_thr);
         g = '0;
         if (dx < thr && dy < thr) begin
            // tap: scale the first point, then the strict circle test
            px = longint'(first_x) * SCR_W / PANEL_W;
            py = longint'(first_y) * SCR_H / PANEL_H;
            ox = longint'(ctr_x);
            ox = px - ox;
            oy = longint'(ctr_y);
            oy = py - oy;
            rad = longint'(radius);
            if (ox * ox + oy * oy < rad * rad) begin
               g.gesture = GEST_CENTER;
            end else begin
               g.gesture = GEST_TAP;
               g.tap_x = px[COORD_W-1:0];
               g.tap_y = py[COORD_W-1:0];
            end
         end else if (dx > dy) begin
            g.gesture = ($signed({1'b0, last_x}) > first_x) ? GEST_RIGHT : GEST_LEFT;
         end else begin
            // ties go to the Y axis; no motion reads as up
            g.gesture = ($signed({1'b0, last_y}) > first_y) ? GEST_DOWN : GEST_UP;
         end
         gestures_due.push_back(g);
         first_x = '1;
         first_y = '1;
         last_x = '0;
         last_y = '0;
      end
   endtask

   // Driver: one request per handshake; payload held while stalled
   int req_gap = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else if (req_valid && req_stall) begin
         // hold the stalled request as it is
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_valid <= 1'b0;
      end else if (pending_requests.size() > 0) begin
         req_valid <= 1'b1;
         req_data <= pending_requests.pop_front();
         if (idling && $urandom_range(0, 7) == 0) req_gap <= $urandom_range(1, 19);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver stall: random bursts, plus one long hold-off that lets the block fill
   int stall_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 18);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check the result taken at this edge, then predict from the
   // request taken at this edge (a result never leaves in its request's cycle)
   always @(posedge clock) begin : monitor
      rsp_type due;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (gestures_due.size() == 0) begin
               $error("result with nothing expected: gesture %0d tap_x %0d tap_y %0d",
                      rsp_data.gesture, rsp_data.tap_x, rsp_data.tap_y);
               failed = 1'b1;
            end else begin
               due = gestures_due.pop_front();
               if (rsp_data.gesture !== due.gesture) begin
                  $error("gesture: expected %0d, got %0d", due.gesture, rsp_data.gesture);
                  failed = 1'b1;
               end
               if (rsp_data.tap_x !== due.tap_x) begin
                  $error("tap_x: expected %0d, got %0d", due.tap_x, rsp_data.tap_x);
                  failed = 1'b1;
               end
               if (rsp_data.tap_y !== due.tap_y) begin
                  $error("tap_y: expected %0d, got %0d", due.tap_y, rsp_data.tap_y);
                  failed = 1'b1;
               end
            end
            results_seen <= results_seen + 1;
         end
         if (req_valid && !req_stall) track_request(req_data);
      end
   end

   function automatic logic [COORD_W-1:0] clamp_coord(input int v);
      if (v < 0) return '0;
      if (v > int'(COORD_MAX)) return '1;
      return v[COORD_W-1:0];
   endfunction

   task automatic queue_request(input logic [TYPE_W-1:0] t, input logic [CODE_W-1:0] c,
                                input logic [COORD_W-1:0] v);
      req_type rq;
      rq.event_type = t;
      rq.event_code = c;
      rq.event_value = v;
      pending_requests.push_back(rq);
      // ignored requests do not count toward the stimulus size
      if ((t == EV_TYPE_ABS && (c == CODE_AXIS_X || c == CODE_AXIS_Y)) ||
          (t == EV_TYPE_KEY && c == CODE_TOUCH && v == VALUE_RELEASE))
         requests_queued++;
   endtask

   task automatic queue_point(input int x, input int y, input bit skip_x, input bit skip_y);
      if (!skip_x) queue_request(EV_TYPE_ABS, CODE_AXIS_X, clamp_coord(x));
      if (!skip_y) queue_request(EV_TYPE_ABS, CODE_AXIS_Y, clamp_coord(y));
   endtask

   task automatic queue_noise();
      logic [$bits(req_type)-1:0] bits;
      req_type rq;
      if ($urandom_range(0, 2) == 0) begin
         queue_request(EV_TYPE_KEY, CODE_TOUCH,
                       COORD_W'($urandom_range(1, COORD_MAX)));  // press
      end else begin
         bits = $bits(req_type)'($urandom);
         rq = bits;
         queue_request(rq.event_type, rq.event_code, rq.event_value);
      end
   endtask

   // One random touch: mostly well formed, sometimes aimed at the button,
   // sometimes with noise, a missing axis or no release at all
   task automatic queue_touch();
      int kind, x0, y0, x1, y1, span, reach, d, steps;
      bit skip_x, skip_y;
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
         reach = int'(radius) * 5 / 4 + 8;
         x0 = int'(ctr_x) * int'(RAW_WIDTH) / int'(SCREEN_WIDTH) +
              $urandom_range(0, 2 * reach) - reach;
         y0 = int'(ctr_y) * int'(RAW_HEIGHT) / int'(SCREEN_HEIGHT) +
              $urandom_range(0, 2 * reach) - reach;
      end else begin
         x0 = $urandom_range(0, COORD_MAX);
         y0 = $urandom_range(0, COORD_MAX);
      end
      if (kind < 6) span = $urandom_range(0, int'(tap_thr) + 4);   // around the tap limit
      else span = $urandom_range(0, COORD_MAX);
      x1 = x0 + $urandom_range(0, 2 * span) - span;
      y1 = y0 + $urandom_range(0, 2 * span) - span;
      if (kind == 9) begin
         // equal displacement on both axes
         d = $urandom_range(0, 300);
         x1 = x0 + ($urandom_range(0, 1) ? d : -d);
         y1 = y0 + ($urandom_range(0, 1) ? d : -d);
      end
      skip_x = ($urandom_range(0, 11) == 0);
      skip_y = ($urandom_range(0, 11) == 0);
      queue_point(x0, y0, skip_x, skip_y);
      steps = $urandom_range(0, 3);
      repeat (steps) begin
         queue_point(x0 + $urandom_range(0, 2 * span) - span,
                     y0 + $urandom_range(0, 2 * span) - span, skip_x, skip_y);
         if ($urandom_range(0, 9) == 0) queue_noise();
      end
      queue_point(x1, y1, skip_x, skip_y);
      if ($urandom_range(0, 5) == 0) queue_noise();
      if ($urandom_range(0, 11) != 0) queue_request(EV_TYPE_KEY, CODE_TOUCH, VALUE_RELEASE);
   endtask

   // Block idle: every request taken, every result back, then settle
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || gestures_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_TAP_THRESHOLD:   tap_thr = value;
         CSR_BUTTON_CENTER_X: ctr_x = value;
         CSR_BUTTON_CENTER_Y: ctr_y = value;
         CSR_BUTTON_RADIUS:   radius = value;
      endcase
   endtask

   cfg_type settings[6];
   int goal;

   initial begin
      settings[0] = '{tap_threshold: 10'd0, button_center_x: 10'd0,
                      button_center_y: 10'd0, button_radius: 10'd0};   // never a tap
      settings[1] = '{tap_threshold: 10'd1023, button_center_x: 10'd1023,
                      button_center_y: 10'd1023,
                      button_radius: 10'd1023};          // nearly everything a tap
      settings[2] = '{tap_threshold: 10'd15, button_center_x: 10'd0,
                      button_center_y: 10'd0, button_radius: 10'd0};   // empty button
      settings[3] = '{tap_threshold: 10'd20, button_center_x: 10'd400,
                      button_center_y: 10'd240, button_radius: 10'd300};
      settings[4] = '{tap_threshold: CFG_W'($urandom_range(1, 40)),
                      button_center_x: CFG_W'($urandom),
                      button_center_y: CFG_W'($urandom),
                      button_radius: CFG_W'($urandom_range(0, 400))};
      settings[5] = '{tap_threshold: TAP_THRESHOLD_RST, button_center_x: BUTTON_CENTER_X_RST,
                      button_center_y: BUTTON_CENTER_Y_RST,
                      button_radius: BUTTON_RADIUS_RST};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, reset register values.
      // Tap on the center button: raw (500,575) scales to (400,460).
      queue_point(500, 575, 1'b0, 1'b0);
      queue_request(EV_TYPE_KEY, CODE_TOUCH, VALUE_RELEASE);
      // Release with no axis seen: both starts are -1 and scale to 0.
      queue_request(EV_TYPE_KEY, CODE_TOUCH, VALUE_RELEASE);
      // Plain tap at the panel corner, scaled coordinates at their maximum.
      queue_point(1023, 1023, 1'b0, 1'b0);
      queue_request(EV_TYPE_KEY, CODE_TOUCH, VALUE_RELEASE);
      // Equal displacement, decreasing: Y decides, up.
      queue_point(200, 200, 1'b0, 1'b0);
      queue_point(100, 100, 1'b0, 1'b0);
      queue_request(EV_TYPE_KEY, CODE_TOUCH, VALUE_RELEASE);
      // Y axis only, full range: down.
      queue_point(0, 0, 1'b1, 1'b0);
      queue_point(0, 1023, 1'b1, 1'b0);
      queue_request(EV_TYPE_KEY, CODE_TOUCH, VALUE_RELEASE);
      // Full-range swipe left, with ignored requests inside the touch.
      queue_point(1023, 0, 1'b0, 1'b0);
      queue_request(EV_TYPE_KEY, CODE_TOUCH, 10'd1);          // key press
      queue_request(EV_TYPE_KEY, CODE_TOUCH + 10'd1, VALUE_RELEASE);
      queue_request(EV_TYPE_ABS, 10'd2, 10'd5);                // other axis
      queue_request('1, '1, '1);                               // other type
      queue_request('0, '0, '0);
      queue_point(0, 0, 1'b0, 1'b1);
      queue_request(EV_TYPE_KEY, CODE_TOUCH, VALUE_RELEASE);
      // X axis only: right.
      queue_point(0, 0, 1'b0, 1'b1);
      queue_point(1023, 0, 1'b0, 1'b1);
      queue_request(EV_TYPE_KEY, CODE_TOUCH, VALUE_RELEASE);
      wait_idle();

      // Random part, one phase per register setting; the last runs without idling
      goal = requests_queued;
      foreach (settings[i]) begin
         write_register(CSR_TAP_THRESHOLD, settings[i].tap_threshold);
         write_register(CSR_BUTTON_CENTER_X, settings[i].button_center_x);
         write_register(CSR_BUTTON_CENTER_Y, settings[i].button_center_y);
         write_register(CSR_BUTTON_RADIUS, settings[i].button_radius);
         if (i == 5) idling = 1'b0;
         goal += 108;
         while (requests_queued < goal) queue_touch();
         wait_idle();
      end

      if (failed) begin
         $display("TB_ERROR");
      end else begin
         $display("TB_OK");
      end
      $finish;
   end

endmodule

/* touch_gesture_classifier.f */
design/gtc_pkg.sv
design/gtc_mul_unit.sv
design/gtc_touch_state.sv
design/gtc_sequencer.sv
design/touch_gesture_classifier.sv
test/touch_gesture_classifier_test.sv
